// ----- rtl/core/mpeb_pkg.sv -----
package mpeb_pkg;

   // result status codes
   localparam logic [1:0] ST_MADE    = 2'd0;
   localparam logic [1:0] ST_CLOSED  = 2'd1;
   localparam logic [1:0] ST_REFUSED = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_TOTAL_SECTORS = 2'd0;
   localparam logic [1:0] CSR_SECTOR_LOG2   = 2'd1;
   localparam logic [1:0] CSR_ALIGN_LOG2    = 2'd2;

   localparam logic [31:0] TOTAL_RESET       = 32'd2048;
   localparam logic [4:0]  SECTOR_LOG2_RESET = 5'd9;
   localparam logic [4:0]  ALIGN_LOG2_RESET  = 5'd12;

   localparam logic [4:0] SECTOR_LOG2_MIN = 5'd9;
   localparam logic [4:0] SECTOR_LOG2_MAX = 5'd16;
   localparam logic [4:0] ALIGN_LOG2_MAX  = 5'd24;
   localparam logic [4:0] MB_LOG2         = 5'd20;

   localparam logic [7:0] PCT_FULL  = 8'd100;
   localparam logic [7:0] BOOT_MARK = 8'h80;
   localparam logic [7:0] HEADS     = 8'd255;
   localparam logic [5:0] SECS      = 6'd63;

   // reciprocal constants: q = (x * MAGIC) >> SHIFT
   localparam logic [31:0] DIV100_MAGIC       = 32'h51EB851F;  // 32-bit x, shift 37
   localparam logic [12:0] DIV100_SMALL_MAGIC = 13'd5243;      // x < 43699, shift 19
   localparam logic [32:0] DIV63_MAGIC        = 33'h104104105; // 32-bit x, shift 38
   localparam logic [26:0] DIV255_MAGIC       = 27'd67372037;  // x < 68445694, shift 34

   typedef struct packed {
      logic        new_table;
      logic        pct_zero;
      logic        want;
      logic [7:0]  kind;
      logic        big;
      logic [31:0] req;
   } size_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  index;
      logic [7:0]  boot;
      logic [7:0]  kind;
      logic [31:0] start;
      logic [31:0] count;
   } entry_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  entry_index;
      logic [7:0]  boot_flag;
      logic [7:0]  start_head;
      logic [7:0]  start_sec_cyl;
      logic [7:0]  start_cyl_low;
      logic [7:0]  kind_out;
      logic [7:0]  end_head;
      logic [7:0]  end_sec_cyl;
      logic [7:0]  end_cyl_low;
      logic [31:0] start_lba;
      logic [31:0] sector_count;
   } rsp_word_type;

endpackage

// ----- rtl/core/mpeb_size.sv -----
module mpeb_size (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic                    in_new_table,
   input  logic [7:0]              in_pct,
   input  logic [31:0]             in_mb,
   input  logic                    in_want,
   input  logic [7:0]              in_kind,
   input  logic [31:0]             usable,
   input  logic [3:0]              mb_shift,
   output logic                    out_valid,
   output mpeb_pkg::size_word_type out_word
);
   import mpeb_pkg::*;

   // stage a: usable / 100 and scaled megabytes
   logic [63:0] q100_prod;
   logic [42:0] mb_wide;
   logic        va_ff;
   logic [31:0] usable_a_ff;
   logic [25:0] q_a_ff;
   logic [7:0]  pct_a_ff;
   logic [31:0] mb_a_ff;
   logic        big_a_ff;
   logic        nt_a_ff;
   logic        want_a_ff;
   logic [7:0]  kind_a_ff;

   // stage b: split product usable*pct = q*pct + r*pct
   logic [31:0] rem_full;
   logic [6:0]  rem_a;
   logic [33:0] hi_in;
   logic [14:0] lo_in;
   logic        vb_ff;
   logic [33:0] hi_b_ff;
   logic [14:0] lo_b_ff;
   logic [7:0]  pct_b_ff;
   logic [31:0] mb_b_ff;
   logic        big_b_ff;
   logic        nt_b_ff;
   logic        want_b_ff;
   logic [7:0]  kind_b_ff;

   // stage c: finish the percentage, pick the rule
   logic [27:0]   lo_prod;
   logic [7:0]    lo_q;
   logic [33:0]   pct_sum;
   logic          is_mb;
   size_word_type word_in;
   logic          vc_ff;
   size_word_type word_ff;

   assign q100_prod = 64'(usable) * 64'(DIV100_MAGIC);
   assign mb_wide   = 43'(in_mb) << mb_shift;

   assign rem_full = usable_a_ff - (32'(q_a_ff) * 32'd100);
   assign rem_a    = rem_full[6:0];
   assign hi_in    = 34'(q_a_ff) * 34'(pct_a_ff);
   assign lo_in    = 15'(rem_a) * 15'(pct_a_ff);

   assign lo_prod = 28'(lo_b_ff) * 28'(DIV100_SMALL_MAGIC);
   assign lo_q    = lo_prod[26:19];
   assign pct_sum = hi_b_ff + 34'(lo_q);
   assign is_mb   = pct_b_ff > PCT_FULL;

   always_comb begin
      word_in.new_table = nt_b_ff;
      word_in.pct_zero  = (pct_b_ff == 8'd0);
      word_in.want      = want_b_ff;
      word_in.kind      = kind_b_ff;
      word_in.big       = is_mb & big_b_ff;
      word_in.req       = is_mb ? mb_b_ff : pct_sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         usable_a_ff <= usable;
         q_a_ff      <= q100_prod[62:37];
         pct_a_ff    <= in_pct;
         mb_a_ff     <= mb_wide[31:0];
         big_a_ff    <= |mb_wide[42:32];
         nt_a_ff     <= in_new_table;
         want_a_ff   <= in_want;
         kind_a_ff   <= in_kind;

         hi_b_ff   <= hi_in;
         lo_b_ff   <= lo_in;
         pct_b_ff  <= pct_a_ff;
         mb_b_ff   <= mb_a_ff;
         big_b_ff  <= big_a_ff;
         nt_b_ff   <= nt_a_ff;
         want_b_ff <= want_a_ff;
         kind_b_ff <= kind_a_ff;

         word_ff <= word_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_word  = word_ff;

endmodule

// ----- rtl/core/mpeb_layout.sv -----
module mpeb_layout #(
   parameter int MAX_ENTRIES    = 4,
   parameter int RESERVED_START = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  mpeb_pkg::size_word_type  in_word,
   input  logic [31:0]              usable,
   input  logic [3:0]               align_shift,
   output logic                     out_valid,
   output mpeb_pkg::entry_word_type out_word
);
   import mpeb_pkg::*;

   localparam logic [31:0] RES_START  = 32'(RESERVED_START);
   localparam logic [31:0] RESET_LEFT =
      (TOTAL_RESET < RES_START) ? 32'd0 : (TOTAL_RESET - RES_START);
   localparam logic [2:0]  ENTRY_LIMIT = 3'(MAX_ENTRIES);

   logic        [31:0] next_start_ff, next_start_in;
   logic        [31:0] left_ff, left_in;
   logic               active_ff, active_in;
   logic        [2:0]  made_ff, made_in;
   logic               closed_ff, closed_in;
   logic               out_valid_ff;
   entry_word_type     entry_ff, entry_in;

   logic [31:0] cur_next;
   logic [31:0] cur_left;
   logic        cur_active;
   logic [2:0]  cur_made;
   logic        cur_closed;
   logic        refuse;
   logic [31:0] align_mask;
   logic [31:0] clipped;
   logic [31:0] count;
   logic        take_boot;

   always_comb begin
      // new_table restarts the layout before this word is handled
      cur_next   = in_word.new_table ? RES_START : next_start_ff;
      cur_left   = in_word.new_table ? usable    : left_ff;
      cur_active = in_word.new_table ? 1'b0      : active_ff;
      cur_made   = in_word.new_table ? 3'd0      : made_ff;
      cur_closed = in_word.new_table ? 1'b0      : closed_ff;

      refuse     = cur_closed || (cur_made >= ENTRY_LIMIT);
      align_mask = 32'hFFFF_FFFF << align_shift;
      clipped    = (in_word.big || (in_word.req > cur_left)) ? cur_left : in_word.req;
      count      = in_word.pct_zero ? cur_left : (clipped & align_mask);
      take_boot  = in_word.want && !cur_active;

      next_start_in = cur_next;
      left_in       = cur_left;
      active_in     = cur_active;
      made_in       = cur_made;
      closed_in     = cur_closed;
      entry_in      = '0;

      if (refuse) begin
         entry_in.status = ST_REFUSED;
      end else begin
         next_start_in   = cur_next + count;
         left_in         = cur_left - count;
         active_in       = cur_active | take_boot;
         made_in         = cur_made + 3'd1;
         closed_in       = cur_closed | in_word.pct_zero;
         entry_in.status = in_word.pct_zero ? ST_CLOSED : ST_MADE;
         entry_in.index  = cur_made[1:0];
         entry_in.boot   = take_boot ? BOOT_MARK : 8'd0;
         entry_in.kind   = in_word.kind;
         entry_in.start  = cur_next;
         entry_in.count  = count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_start_ff <= RES_START;
         left_ff       <= RESET_LEFT;
         active_ff     <= 1'b0;
         made_ff       <= 3'd0;
         closed_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
         if (in_valid) begin
            next_start_ff <= next_start_in;
            left_ff       <= left_in;
            active_ff     <= active_in;
            made_ff       <= made_in;
            closed_ff     <= closed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         entry_ff <= entry_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = entry_ff;

endmodule

// ----- rtl/core/mpeb_chs.sv -----
module mpeb_chs (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  mpeb_pkg::entry_word_type in_word,
   output logic                     out_valid,
   output mpeb_pkg::rsp_word_type   out_word
);
   import mpeb_pkg::*;

   // lane 0 converts the first sector, lane 1 the last
   logic           vd_ff, ve_ff, vf_ff, vg_ff;
   entry_word_type ent_d_ff, ent_e_ff, ent_f_ff;
   rsp_word_type   rsp_ff, rsp_in;

   logic [31:0] last_in;
   logic [31:0] lba_d_ff [2];

   logic [64:0] q63_prod [2];
   logic [31:0] lba_e_ff [2];
   logic [26:0] q63_e_ff [2];

   logic [31:0] rem63    [2];
   logic [52:0] cyl_prod [2];
   logic [5:0]  sec_f_ff [2];
   logic [18:0] cyl_f_ff [2];
   logic [26:0] q63_f_ff [2];

   logic [26:0] head_full [2];
   logic [7:0]  head      [2];
   logic [7:0]  sec_cyl   [2];

   assign last_in = (in_word.count == 32'd0) ? in_word.start
                                             : (in_word.start + in_word.count - 32'd1);

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         q63_prod[i]  = 65'(lba_d_ff[i]) * 65'(DIV63_MAGIC);
         rem63[i]     = lba_e_ff[i] - (32'(q63_e_ff[i]) * 32'(SECS));
         cyl_prod[i]  = 53'(q63_e_ff[i]) * 53'(DIV255_MAGIC);
         head_full[i] = q63_f_ff[i] - (27'(cyl_f_ff[i]) * 27'(HEADS));
         head[i]      = head_full[i][7:0];
         sec_cyl[i]   = {cyl_f_ff[i][9:8], sec_f_ff[i]};
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = ent_f_ff.status;
      if (ent_f_ff.status != ST_REFUSED) begin
         rsp_in.entry_index   = ent_f_ff.index;
         rsp_in.boot_flag     = ent_f_ff.boot;
         rsp_in.start_head    = head[0];
         rsp_in.start_sec_cyl = sec_cyl[0];
         rsp_in.start_cyl_low = cyl_f_ff[0][7:0];
         rsp_in.kind_out      = ent_f_ff.kind;
         rsp_in.end_head      = head[1];
         rsp_in.end_sec_cyl   = sec_cyl[1];
         rsp_in.end_cyl_low   = cyl_f_ff[1][7:0];
         rsp_in.start_lba     = ent_f_ff.start;
         rsp_in.sector_count  = ent_f_ff.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= in_valid;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_d_ff    <= in_word;
         lba_d_ff[0] <= in_word.start;
         lba_d_ff[1] <= last_in;

         ent_e_ff <= ent_d_ff;
         ent_f_ff <= ent_e_ff;
         for (int i = 0; i < 2; i++) begin
            lba_e_ff[i] <= lba_d_ff[i];
            q63_e_ff[i] <= q63_prod[i][64:38];
            sec_f_ff[i] <= rem63[i][5:0] + 6'd1;
            cyl_f_ff[i] <= cyl_prod[i][52:34];
            q63_f_ff[i] <= q63_e_ff[i];
         end

         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vg_ff;
   assign out_word  = rsp_ff;

endmodule

// ----- rtl/core/mbr_partition_entry_builder_unit.sv -----
// MBR partition entry builder.
// Request channel (req_*): one partition request per word; new_table restarts
// the layout at the reserved start sector, size_pct picks remainder (0),
// percent of the usable sectors (1..100) or size_mb (above 100).
// Response channel (rsp_*): one 16-byte table entry per request, split into
// fields, or status 2 when the table is full or closed.
// csr_*: total sector count, log2 sector size and log2 alignment; written
// with csr_we, taken at once; the user must write them only while no request
// is in flight, as the block itself does not enforce it.
// Throughput: one request per cycle unless stalled; the running start sector
// and sectors left close over a single compare, subtract and add each cycle.
// The pipeline advances as a whole whenever the output register is empty
// or being taken; while a response waits with rsp_ready low the whole pipe
// holds and req_ready drops with it, so words queue in place, none lost.
// Reset (synchronous) empties the pipe, restores the register defaults and
// clears the layout state: next start at the reserved sector, no entries,
// no boot mark given.
module mbr_partition_entry_builder_unit #(
   parameter int MAX_ENTRIES    = 4,
   parameter int RESERVED_START = 2048
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_new_table,
   input  logic [7:0]  req_size_pct,
   input  logic [31:0] req_size_mb,
   input  logic        req_want_active,
   input  logic [7:0]  req_part_kind,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_entry_index,
   output logic [7:0]  rsp_boot_flag,
   output logic [7:0]  rsp_start_head,
   output logic [7:0]  rsp_start_sec_cyl,
   output logic [7:0]  rsp_start_cyl_low,
   output logic [7:0]  rsp_kind_out,
   output logic [7:0]  rsp_end_head,
   output logic [7:0]  rsp_end_sec_cyl,
   output logic [7:0]  rsp_end_cyl_low,
   output logic [31:0] rsp_start_lba,
   output logic [31:0] rsp_sector_count,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import mpeb_pkg::*;

   localparam logic [31:0] RES_START = 32'(RESERVED_START);

   logic [31:0] total_ff;
   logic [4:0]  ssl_ff;
   logic [4:0]  align_ff;

   logic [4:0]  ssl_eff;
   logic [4:0]  align_eff;
   logic [3:0]  align_shift;
   logic [3:0]  mb_shift;
   logic [31:0] usable;

   logic        adv;
   logic        v0_ff;
   logic        nt0_ff;
   logic [7:0]  pct0_ff;
   logic [31:0] mb0_ff;
   logic        want0_ff;
   logic [7:0]  kind0_ff;

   logic           size_valid;
   size_word_type  size_word;
   logic           entry_valid;
   entry_word_type entry_word;
   logic           out_valid;
   rsp_word_type   out_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
         ssl_ff   <= SECTOR_LOG2_RESET;
         align_ff <= ALIGN_LOG2_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOTAL_SECTORS: total_ff <= csr_wdata;
            CSR_SECTOR_LOG2:   ssl_ff   <= csr_wdata[4:0];
            CSR_ALIGN_LOG2:    align_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (ssl_ff < SECTOR_LOG2_MIN) begin
         ssl_eff = SECTOR_LOG2_MIN;
      end else if (ssl_ff > SECTOR_LOG2_MAX) begin
         ssl_eff = SECTOR_LOG2_MAX;
      end else begin
         ssl_eff = ssl_ff;
      end
      if (align_ff < ssl_eff) begin
         align_eff = ssl_eff;
      end else if (align_ff > ALIGN_LOG2_MAX) begin
         align_eff = ALIGN_LOG2_MAX;
      end else begin
         align_eff = align_ff;
      end
   end

   assign align_shift = 4'(align_eff - ssl_eff);
   assign mb_shift    = 4'(MB_LOG2 - ssl_eff);
   assign usable      = (total_ff < RES_START) ? 32'd0 : (total_ff - RES_START);

   assign adv       = ~out_valid | rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nt0_ff   <= req_new_table;
         pct0_ff  <= req_size_pct;
         mb0_ff   <= req_size_mb;
         want0_ff <= req_want_active;
         kind0_ff <= req_part_kind;
      end
   end

   mpeb_size u_size (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (v0_ff),
      .in_new_table (nt0_ff),
      .in_pct       (pct0_ff),
      .in_mb        (mb0_ff),
      .in_want      (want0_ff),
      .in_kind      (kind0_ff),
      .usable       (usable),
      .mb_shift     (mb_shift),
      .out_valid    (size_valid),
      .out_word     (size_word)
   );

   mpeb_layout #(
      .MAX_ENTRIES    (MAX_ENTRIES),
      .RESERVED_START (RESERVED_START)
   ) u_layout (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (size_valid),
      .in_word     (size_word),
      .usable      (usable),
      .align_shift (align_shift),
      .out_valid   (entry_valid),
      .out_word    (entry_word)
   );

   mpeb_chs u_chs (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (entry_valid),
      .in_word   (entry_word),
      .out_valid (out_valid),
      .out_word  (out_word)
   );

   assign rsp_valid         = out_valid;
   assign rsp_status        = out_word.status;
   assign rsp_entry_index   = out_word.entry_index;
   assign rsp_boot_flag     = out_word.boot_flag;
   assign rsp_start_head    = out_word.start_head;
   assign rsp_start_sec_cyl = out_word.start_sec_cyl;
   assign rsp_start_cyl_low = out_word.start_cyl_low;
   assign rsp_kind_out      = out_word.kind_out;
   assign rsp_end_head      = out_word.end_head;
   assign rsp_end_sec_cyl   = out_word.end_sec_cyl;
   assign rsp_end_cyl_low   = out_word.end_cyl_low;
   assign rsp_start_lba     = out_word.start_lba;
   assign rsp_sector_count  = out_word.sector_count;

endmodule

// ----- rtl/core/mpeb_checker.sv -----
module mpeb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_boot_flag,
   input logic [7:0]  rsp_start_head,
   input logic [7:0]  rsp_start_sec_cyl,
   input logic [7:0]  rsp_start_cyl_low,
   input logic [7:0]  rsp_end_head,
   input logic [7:0]  rsp_end_sec_cyl,
   input logic [7:0]  rsp_end_cyl_low,
   input logic [31:0] rsp_start_lba,
   input logic [31:0] rsp_sector_count
);
   import mpeb_pkg::*;

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_start_lba) && $stable(rsp_sector_count))
      else $error("response word changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_REFUSED |->
         rsp_sector_count == 32'd0 && rsp_start_lba == 32'd0
         && rsp_boot_flag == 8'd0 && rsp_start_head == 8'd0)
      else $error("refused word carries entry data");

   // CHS sectors count from one and heads stop below 255
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_REFUSED |->
         rsp_start_sec_cyl[5:0] != 6'd0 && rsp_end_sec_cyl[5:0] != 6'd0
         && rsp_start_head != HEADS && rsp_end_head != HEADS)
      else $error("CHS field out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_REFUSED && rsp_sector_count == 32'd0 |->
         rsp_end_head == rsp_start_head && rsp_end_sec_cyl == rsp_start_sec_cyl
         && rsp_end_cyl_low == rsp_start_cyl_low)
      else $error("empty entry with end CHS apart from start");

endmodule

bind mbr_partition_entry_builder_unit mpeb_checker u_mpeb_checker (.*);
